// ===== rtl/core/priority_round_robin_task_scheduler_macros.svh =====
`ifndef PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PRRTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PRRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/prrts_pkg.sv =====
`default_nettype none
package prrts_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  localparam logic [3:0] PRIO_MAX = 4'd9;
  localparam logic [7:0] SLICE_RESET = 8'd10;
  localparam logic [7:0] USED_MAX = 8'hFF;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_KILL    = 3'd2,
    CMD_SLEEP   = 3'd3,
    CMD_SETPRIO = 3'd4,
    CMD_BLOCK   = 3'd5,
    CMD_UNBLOCK = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    SLOT_DEAD     = 3'd0,
    SLOT_READY    = 3'd1,
    SLOT_RUNNING  = 3'd2,
    SLOT_SLEEPING = 3'd3,
    SLOT_BLOCKED  = 3'd4
  } slot_st_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_SCAN,
    CTL_APPLY
  } ctl_state_t;

  typedef struct packed {
    slot_st_t    st;
    logic [3:0]  prio;
    logic [7:0]  slice;
    logic [7:0]  used;
    logic [31:0] sleep_left;
  } slot_rec_t;

  function automatic logic [3:0] clamp_prio(input logic [7:0] p);
    return (p > 8'(PRIO_MAX)) ? PRIO_MAX : p[3:0];
  endfunction

  function automatic logic [7:0] slice_for(input logic [7:0] base, input logic [3:0] p);
    return (base > 8'(p)) ? (base - 8'(p)) : 8'd0;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/prrts_cell.sv =====
`default_nettype none
module prrts_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  shift_en,
  input  prrts_pkg::slot_rec_t init_rec,
  input  prrts_pkg::slot_rec_t d_in,
  output prrts_pkg::slot_rec_t q
);
  import prrts_pkg::*;

  slot_rec_t rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= init_rec;
    end else if (shift_en) begin
      rec_r <= d_in;
    end
  end

  assign q = rec_r;

endmodule
`default_nettype wire

// ===== rtl/core/priority_round_robin_task_scheduler.sv =====
`default_nettype none
// Task slot scheduler. Pulse start while busy is low to issue one command; its
// transaction is answered by a single-cycle out_valid strobe after the write turn,
// and busy is already low in that cycle,
// so the next command may be issued alongside the strobe. The slot records sit
// in a ring of cells that rotates once per cycle while busy: one full turn gathers the
// tick updates and the scheduling choice, a second turn writes the changes.
// The receiver cannot stall, so out_* must be captured when out_valid is high.
module priority_round_robin_task_scheduler (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [2:0]  in_cmd,
  input  wire  [7:0]  in_task_id,
  input  wire  [7:0]  in_prio_in,
  input  wire  [31:0] in_sleep_len,
  input  wire  [31:0] in_entry_addr,
  input  wire         cfg_wr_en,
  input  wire  [7:0]  cfg_wr_data,
  output logic        out_valid,
  output logic        out_status,
  output logic [3:0]  out_new_id,
  output logic        out_switched,
  output logic [3:0]  out_prev_task,
  output logic [3:0]  out_running_task,
  output logic [31:0] out_tick_total,
  output logic [4:0]  out_live_tasks
);
  import prrts_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic shift_en;
  logic accept;

  slot_rec_t cell_q [SLOT_COUNT];
  slot_rec_t init_rec [SLOT_COUNT];
  slot_rec_t head_upd;

  logic [7:0]        slice_base_r;
  logic [2:0]        cmd_r;
  logic [7:0]        id_r;
  logic [7:0]        prio_r;
  logic [31:0]       sleep_r;
  logic [31:0]       entry_r;
  logic [SLOT_W-1:0] pos_r;
  logic [SLOT_W-1:0] cur_r, cur_nxt;
  logic [31:0]       tick_r;
  logic [CNT_W-1:0]  live_r, live_nxt;

  logic              expired_r, expired_nxt;
  logic              found_r, found_nxt;
  logic [3:0]        best_prio_r, best_prio_nxt;
  logic [SLOT_W:0]   best_gap_r, best_gap_nxt;
  logic [SLOT_W-1:0] best_idx_r, best_idx_nxt;
  logic              dead_found_r, dead_found_nxt;
  logic [SLOT_W-1:0] dead_idx_r, dead_idx_nxt;
  logic              kill_ok_r, kill_ok_nxt;
  logic              kill_err_r, kill_err_nxt;

  logic              last_pos;
  logic              id_ok;
  logic [SLOT_W-1:0] tgt;
  logic              create_ok;
  logic              switch_go;
  logic              status_nxt;
  logic [SLOT_W:0]   ring_gap;
  logic [7:0]        used_inc;

  assign accept   = start && (state_r == CTL_IDLE);
  assign last_pos = (pos_r == SLOT_W'(SLOT_COUNT - 1));
  assign id_ok    = (id_r < 8'(SLOT_COUNT));
  assign tgt      = id_r[SLOT_W-1:0];
  assign create_ok = (live_r < CNT_W'(SLOT_COUNT)) && (entry_r != 32'd0) && dead_found_r;
  assign switch_go = (cmd_r == CMD_TICK) && expired_r && found_r && (best_idx_r != cur_r);

  // Ring of slot cells: cell 0 is the head, the updated head re-enters at the tail.
  genvar k;
  generate
    for (k = 0; k < SLOT_COUNT; k++) begin : g_cell
      always_comb begin
        init_rec[k] = '{st: SLOT_DEAD, prio: 4'd0, slice: 8'd0, used: 8'd0,
                        sleep_left: 32'd0};
        if (k == 0) begin
          init_rec[k].st    = SLOT_RUNNING;
          init_rec[k].slice = SLICE_RESET;
        end
      end
      if (k == SLOT_COUNT - 1) begin : g_tail
        prrts_cell u_cell (
          .clk(clk), .rst_n(rst_n), .shift_en(shift_en), .init_rec(init_rec[k]),
          .d_in(head_upd), .q(cell_q[k])
        );
      end else begin : g_body
        prrts_cell u_cell (
          .clk(clk), .rst_n(rst_n), .shift_en(shift_en), .init_rec(init_rec[k]),
          .d_in(cell_q[k+1]), .q(cell_q[k])
        );
      end
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CTL_IDLE:  if (start) state_nxt = CTL_SCAN;
      CTL_SCAN:  if (last_pos) state_nxt = CTL_APPLY;
      CTL_APPLY: if (last_pos) state_nxt = CTL_IDLE;
      default:   state_nxt = CTL_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    shift_en = 1'b0;
    case (state_r)
      CTL_IDLE:  busy = 1'b0;
      CTL_SCAN:  shift_en = 1'b1;
      CTL_APPLY: shift_en = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  // Head cell update and scan accumulators.
  always_comb begin
    head_upd       = cell_q[0];
    expired_nxt    = expired_r;
    found_nxt      = found_r;
    best_prio_nxt  = best_prio_r;
    best_gap_nxt   = best_gap_r;
    best_idx_nxt   = best_idx_r;
    dead_found_nxt = dead_found_r;
    dead_idx_nxt   = dead_idx_r;
    kill_ok_nxt    = kill_ok_r;
    kill_err_nxt   = kill_err_r;
    used_inc       = (cell_q[0].used == USED_MAX) ? USED_MAX : cell_q[0].used + 8'd1;
    if (pos_r > cur_r) begin
      ring_gap = {1'b0, pos_r} - {1'b0, cur_r} - 1'b1;
    end else begin
      ring_gap = {1'b0, pos_r} + (SLOT_W+1)'(SLOT_COUNT) - {1'b0, cur_r} - 1'b1;
    end

    if (state_r == CTL_SCAN) begin
      if (cmd_r == CMD_TICK) begin
        if (head_upd.st == SLOT_SLEEPING) begin
          if (head_upd.sleep_left != 32'd0) begin
            head_upd.sleep_left = head_upd.sleep_left - 32'd1;
          end
          if (head_upd.sleep_left == 32'd0) begin
            head_upd.st = SLOT_READY;
          end
        end
        if (pos_r == cur_r) begin
          if (used_inc >= head_upd.slice) begin
            expired_nxt   = 1'b1;
            head_upd.used = 8'd0;
          end else begin
            head_upd.used = used_inc;
          end
        end
      end
      // Lowest priority number wins; ties go to the slot nearest after current.
      if (head_upd.st == SLOT_READY) begin
        if (!found_r || (head_upd.prio < best_prio_r) ||
            ((head_upd.prio == best_prio_r) && (ring_gap < best_gap_r))) begin
          found_nxt     = 1'b1;
          best_prio_nxt = head_upd.prio;
          best_gap_nxt  = ring_gap;
          best_idx_nxt  = pos_r;
        end
      end
      if ((cell_q[0].st == SLOT_DEAD) && !dead_found_r) begin
        dead_found_nxt = 1'b1;
        dead_idx_nxt   = pos_r;
      end
    end else if (state_r == CTL_APPLY) begin
      case (cmd_r)
        CMD_TICK: begin
          if (switch_go) begin
            if ((pos_r == cur_r) && (head_upd.st == SLOT_RUNNING)) begin
              head_upd.st = SLOT_READY;
            end
            if (pos_r == best_idx_r) begin
              head_upd.st = SLOT_RUNNING;
            end
          end
        end
        CMD_CREATE: begin
          if (create_ok && (pos_r == dead_idx_r)) begin
            head_upd.st         = SLOT_READY;
            head_upd.prio       = clamp_prio(prio_r);
            head_upd.slice      = slice_for(slice_base_r, clamp_prio(prio_r));
            head_upd.used       = 8'd0;
            head_upd.sleep_left = 32'd0;
          end
        end
        CMD_KILL: begin
          if (id_ok && (pos_r == tgt)) begin
            if ((tgt == '0) || (head_upd.st == SLOT_DEAD)) begin
              kill_err_nxt = 1'b1;
            end else begin
              kill_ok_nxt = 1'b1;
              head_upd.st = SLOT_DEAD;
            end
          end
        end
        CMD_SLEEP: begin
          if (id_ok && (pos_r == tgt) && (head_upd.st != SLOT_DEAD)) begin
            head_upd.sleep_left = sleep_r;
            head_upd.st         = SLOT_SLEEPING;
          end
        end
        CMD_SETPRIO: begin
          if (id_ok && (pos_r == tgt)) begin
            head_upd.prio  = clamp_prio(prio_r);
            head_upd.slice = slice_for(slice_base_r, clamp_prio(prio_r));
          end
        end
        CMD_BLOCK: begin
          if (id_ok && (pos_r == tgt) && (head_upd.st != SLOT_DEAD)) begin
            head_upd.st = SLOT_BLOCKED;
          end
        end
        CMD_UNBLOCK: begin
          if (id_ok && (pos_r == tgt) && (head_upd.st == SLOT_BLOCKED)) begin
            head_upd.st = SLOT_READY;
          end
        end
        default: head_upd = cell_q[0];
      endcase
    end
  end

  always_comb begin
    cur_nxt    = switch_go ? best_idx_r : cur_r;
    live_nxt   = live_r;
    status_nxt = 1'b0;
    case (cmd_r)
      CMD_TICK: status_nxt = 1'b0;
      CMD_CREATE: begin
        status_nxt = !create_ok;
        if (create_ok) live_nxt = live_r + 1'b1;
      end
      CMD_KILL: begin
        status_nxt = !id_ok || kill_err_nxt;
        if (kill_ok_nxt) live_nxt = live_r - 1'b1;
      end
      CMD_SLEEP, CMD_SETPRIO, CMD_BLOCK, CMD_UNBLOCK: status_nxt = !id_ok;
      default: status_nxt = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= CTL_IDLE;
      slice_base_r <= SLICE_RESET;
      pos_r        <= '0;
      cur_r        <= '0;
      tick_r       <= 32'd0;
      live_r       <= CNT_W'(1);
      out_valid    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      if (cfg_wr_en) begin
        slice_base_r <= cfg_wr_data;
      end
      if (shift_en) begin
        pos_r <= last_pos ? '0 : pos_r + 1'b1;
      end
      if (accept && (in_cmd == CMD_TICK)) begin
        tick_r <= tick_r + 32'd1;
      end
      if ((state_r == CTL_APPLY) && last_pos) begin
        cur_r     <= cur_nxt;
        live_r    <= live_nxt;
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r        <= in_cmd;
      id_r         <= in_task_id;
      prio_r       <= in_prio_in;
      sleep_r      <= in_sleep_len;
      entry_r      <= in_entry_addr;
      expired_r    <= 1'b0;
      found_r      <= 1'b0;
      best_prio_r  <= 4'd0;
      best_gap_r   <= '0;
      best_idx_r   <= '0;
      dead_found_r <= 1'b0;
      dead_idx_r   <= '0;
      kill_ok_r    <= 1'b0;
      kill_err_r   <= 1'b0;
    end else begin
      expired_r    <= expired_nxt;
      found_r      <= found_nxt;
      best_prio_r  <= best_prio_nxt;
      best_gap_r   <= best_gap_nxt;
      best_idx_r   <= best_idx_nxt;
      dead_found_r <= dead_found_nxt;
      dead_idx_r   <= dead_idx_nxt;
      kill_ok_r    <= kill_ok_nxt;
      kill_err_r   <= kill_err_nxt;
    end
    if ((state_r == CTL_APPLY) && last_pos) begin
      out_status       <= status_nxt;
      out_new_id       <= (cmd_r == CMD_CREATE && create_ok) ? 4'(dead_idx_r) : 4'd0;
      out_switched     <= switch_go;
      out_prev_task    <= 4'(cur_r);
      out_running_task <= 4'(cur_nxt);
      out_tick_total   <= tick_r;
      out_live_tasks   <= 5'(live_nxt);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/prrts_checker.sv =====
`default_nettype none
`include "priority_round_robin_task_scheduler_macros.svh"
module prrts_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        start,
  input wire        busy,
  input wire        out_valid,
  input wire        out_switched,
  input wire [3:0]  out_prev_task,
  input wire [3:0]  out_running_task,
  input wire [4:0]  out_live_tasks
);
  `PRRTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `PRRTS_ASSERT_NOW(a_done_idle, out_valid, !busy, "result shown while still busy")
  `PRRTS_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than one cycle")
  `PRRTS_ASSERT_NOW(a_prev_match, out_valid && !out_switched, out_prev_task == out_running_task, "prev task differs without switch")
  `PRRTS_ASSERT_NOW(a_kernel_live, out_valid, out_live_tasks != 5'd0, "live count reached zero")
endmodule

bind priority_round_robin_task_scheduler prrts_checker u_prrts_checker (.*);
`default_nettype wire

// ===== tb/priority_round_robin_task_scheduler_test.sv =====
`timescale 1ns / 100ps

module priority_round_robin_task_scheduler_test;
  import prrts_pkg::*;

  localparam logic [2:0] CMD_UNKNOWN = 3'd7;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 2 * SLOT_COUNT + 8;

  typedef struct packed {
    bit        status;
    bit [3:0]  new_id;
    bit        switched;
    bit [3:0]  prev_task;
    bit [3:0]  running_task;
    bit [31:0] tick_total;
    bit [4:0]  live_tasks;
  } sched_result_t;

  class sched_scoreboard;
    sched_result_t expected_q[$];
    slot_st_t    slot_st[SLOT_COUNT];
    logic [3:0]  slot_prio[SLOT_COUNT];
    logic [7:0]  slot_slice[SLOT_COUNT];
    logic [7:0]  slot_used[SLOT_COUNT];
    logic [31:0] slot_sleep[SLOT_COUNT];
    logic [3:0]  cur_slot;
    logic [31:0] ticks_seen;
    logic [4:0]  live_count;
    logic [7:0]  slice_base;
    int mismatches, n_ticks, n_switches, n_creates, n_errors, n_results;

    function new();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_st[i] = SLOT_DEAD;
        slot_prio[i] = '0;
        slot_slice[i] = '0;
        slot_used[i] = '0;
        slot_sleep[i] = '0;
      end
      slot_st[0] = SLOT_RUNNING;
      slot_slice[0] = SLICE_RESET;
      cur_slot = '0;
      ticks_seen = '0;
      live_count = 5'd1;
      slice_base = SLICE_RESET;
    endfunction

    function logic [3:0] clamp(logic [7:0] p);
      return (p > 8'(PRIO_MAX)) ? PRIO_MAX : p[3:0];
    endfunction

    function logic [7:0] slice_len(logic [3:0] p);
      return (slice_base > 8'(p)) ? slice_base - 8'(p) : 8'd0;
    endfunction

    // Applies one accepted command to the shadow slot table.
    function void note_command(logic [2:0] cmd, logic [7:0] id, logic [7:0] prio,
                               logic [31:0] slp, logic [31:0] entry);
      sched_result_t r;
      logic [3:0] s, prev_slot, nxt, p;
      logic [7:0] best;
      int idx;
      bit id_ok;
      r = '{default: 0};
      prev_slot = cur_slot;
      id_ok = id < SLOT_COUNT;
      s = id[3:0];
      if (cmd == CMD_TICK) begin
        n_ticks++;
        ticks_seen++;
        if (slot_used[cur_slot] < USED_MAX) slot_used[cur_slot]++;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_st[i] == SLOT_SLEEPING) begin
            if (slot_sleep[i] > 0) slot_sleep[i]--;
            if (slot_sleep[i] == 0) slot_st[i] = SLOT_READY;
          end
        end
        if (slot_used[cur_slot] >= slot_slice[cur_slot]) begin
          slot_used[cur_slot] = '0;
          nxt = cur_slot;
          best = 8'hFF;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            idx = (cur_slot + 1 + i) % SLOT_COUNT;
            if (slot_st[idx] == SLOT_READY && 8'(slot_prio[idx]) < best) begin
              best = 8'(slot_prio[idx]);
              nxt = idx[3:0];
            end
          end
          if (nxt != cur_slot) begin
            if (slot_st[cur_slot] == SLOT_RUNNING) slot_st[cur_slot] = SLOT_READY;
            slot_st[nxt] = SLOT_RUNNING;
            cur_slot = nxt;
            r.switched = 1;
            n_switches++;
          end
        end
      end else if (cmd == CMD_CREATE) begin
        r.status = 1;
        if (live_count < SLOT_COUNT && entry != 0) begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (r.status && slot_st[i] == SLOT_DEAD) begin
              p = clamp(prio);
              slot_st[i] = SLOT_READY;
              slot_prio[i] = p;
              slot_slice[i] = slice_len(p);
              slot_used[i] = '0;
              slot_sleep[i] = '0;
              live_count++;
              r.new_id = i[3:0];
              r.status = 0;
              n_creates++;
            end
          end
        end
      end else if (cmd == CMD_UNKNOWN || !id_ok) begin
        r.status = 1;
      end else if (cmd == CMD_KILL) begin
        if (s == 0 || slot_st[s] == SLOT_DEAD) r.status = 1;
        else begin
          slot_st[s] = SLOT_DEAD;
          live_count--;
        end
      end else if (cmd == CMD_SLEEP) begin
        if (slot_st[s] != SLOT_DEAD) begin
          slot_sleep[s] = slp;
          slot_st[s] = SLOT_SLEEPING;
        end
      end else if (cmd == CMD_SETPRIO) begin
        p = clamp(prio);
        slot_prio[s] = p;
        slot_slice[s] = slice_len(p);
      end else if (cmd == CMD_BLOCK) begin
        if (slot_st[s] != SLOT_DEAD) slot_st[s] = SLOT_BLOCKED;
      end else begin
        if (slot_st[s] == SLOT_BLOCKED) slot_st[s] = SLOT_READY;
      end
      if (r.status) n_errors++;
      r.prev_task = r.switched ? prev_slot : cur_slot;
      r.running_task = cur_slot;
      r.tick_total = ticks_seen;
      r.live_tasks = live_count;
      expected_q.push_back(r);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with no transaction pending");
        return;
      end
      e = expected_q.pop_front();
      n_results++;
      if (got != e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d mismatch: exp st=%0d id=%0d sw=%0d prev=%0d run=%0d tick=%0d live=%0d",
                   n_results, e.status, e.new_id, e.switched, e.prev_task,
                   e.running_task, e.tick_total, e.live_tasks);
          $display("       got st=%0d id=%0d sw=%0d prev=%0d run=%0d tick=%0d live=%0d",
                   got.status, got.new_id, got.switched, got.prev_task,
                   got.running_task, got.tick_total, got.live_tasks);
        end
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  in_cmd = '0;
  logic [7:0]  in_task_id = '0;
  logic [7:0]  in_prio_in = '0;
  logic [31:0] in_sleep_len = '0;
  logic [31:0] in_entry_addr = '0;
  logic        cfg_wr_en = 0;
  logic [7:0]  cfg_wr_data = '0;
  logic        out_valid, out_status, out_switched;
  logic [3:0]  out_new_id, out_prev_task, out_running_task;
  logic [31:0] out_tick_total;
  logic [4:0]  out_live_tasks;

  sched_scoreboard sb = new();
  int idle_cycles = 0;

  priority_round_robin_task_scheduler u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_task_id(in_task_id), .in_prio_in(in_prio_in),
    .in_sleep_len(in_sleep_len), .in_entry_addr(in_entry_addr),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_status(out_status), .out_new_id(out_new_id),
    .out_switched(out_switched), .out_prev_task(out_prev_task),
    .out_running_task(out_running_task), .out_tick_total(out_tick_total),
    .out_live_tasks(out_live_tasks)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    sched_result_t got;
    if (rst_n && out_valid) begin
      got.status = out_status;
      got.new_id = out_new_id;
      got.switched = out_switched;
      got.prev_task = out_prev_task;
      got.running_task = out_running_task;
      got.tick_total = out_tick_total;
      got.live_tasks = out_live_tasks;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_wr_en || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Issues one command after a random gap; start is left high so that a
  // zero gap gives back-to-back transactions.
  task automatic send_command(logic [2:0] cmd, logic [7:0] id, logic [7:0] prio,
                              logic [31:0] slp, logic [31:0] entry);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_task_id <= id;
    in_prio_in <= prio;
    in_sleep_len <= slp;
    in_entry_addr <= entry;
    do @(posedge clk); while (busy);
    sb.note_command(cmd, id, prio, slp, entry);
  endtask

  task automatic write_slice_base(logic [7:0] base);
    start <= 1'b0;
    while (sb.expected_q.size() != 0 || busy) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= base;
    @(posedge clk);
    sb.slice_base = base;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= $urandom;
  endtask

  task automatic send_random();
    logic [2:0]  cmd;
    logic [7:0]  id, prio;
    logic [31:0] slp, entry;
    int w;
    w = $urandom_range(0, 99);
    if (w < 40) cmd = CMD_TICK;
    else if (w < 55) cmd = CMD_CREATE;
    else if (w < 64) cmd = CMD_KILL;
    else if (w < 74) cmd = CMD_SLEEP;
    else if (w < 82) cmd = CMD_SETPRIO;
    else if (w < 89) cmd = CMD_BLOCK;
    else if (w < 97) cmd = CMD_UNBLOCK;
    else cmd = CMD_UNKNOWN;
    id = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, SLOT_COUNT - 1));
    prio = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
    slp = ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(0, 15));
    entry = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
    send_command(cmd, id, prio, slp, entry);
  endtask

  initial begin
    logic [7:0] bases[6];
    bases = '{8'd10, 8'd255, 8'd11, 8'd37, 8'd10, 8'd200};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: rejected creates, clamping, the kernel slot and bad ids.
    send_command(CMD_CREATE, 8'd0, 8'd3, 32'd0, 32'd0);
    send_command(CMD_CREATE, 8'd0, 8'd255, 32'd0, 32'hFFFF_FFFF);
    send_command(CMD_CREATE, 8'd0, 8'd0, 32'd0, 32'd1);
    send_command(CMD_KILL, 8'd0, 8'd0, 32'd0, 32'd0);
    send_command(CMD_KILL, 8'd9, 8'd0, 32'd0, 32'd0);
    send_command(CMD_KILL, 8'd255, 8'd0, 32'd0, 32'd0);
    send_command(CMD_UNKNOWN, 8'd1, 8'd0, 32'd0, 32'd0);
    send_command(CMD_SLEEP, 8'd12, 8'd0, 32'd5, 32'd0);
    send_command(CMD_BLOCK, 8'd12, 8'd0, 32'd0, 32'd0);
    send_command(CMD_UNBLOCK, 8'd1, 8'd0, 32'd0, 32'd0);
    send_command(CMD_SLEEP, 8'd1, 8'd0, 32'd0, 32'd0);
    send_command(CMD_TICK, 8'd0, 8'd0, 32'd0, 32'd0);
    send_command(CMD_SLEEP, 8'd2, 8'd0, 32'hFFFF_FFFF, 32'd0);
    send_command(CMD_SETPRIO, 8'd0, 8'd200, 32'd0, 32'd0);
    send_command(CMD_BLOCK, 8'd1, 8'd0, 32'd0, 32'd0);
    send_command(CMD_UNBLOCK, 8'd1, 8'd0, 32'd0, 32'd0);
    repeat (12) send_command(CMD_TICK, 8'd0, 8'd0, 32'd0, 32'd0);
    // Fill the table past full.
    repeat (16) send_command(CMD_CREATE, 8'd0, 8'($urandom_range(0, 9)), 32'd0, $urandom | 1);

    foreach (bases[i]) begin
      write_slice_base((i == 3) ? 8'($urandom_range(10, 255)) : bases[i]);
      repeat (275) send_random();
    end

    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d results: %0d ticks, %0d switches, %0d creates, %0d error statuses.",
             sb.n_results, sb.n_ticks, sb.n_switches, sb.n_creates, sb.n_errors);
    $display("Slice base swept over %0d settings; %0d mismatches.", 6, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
